// ===== sv/tcs_pkg.sv =====
package tcs_pkg;

  // item kinds carried on the slave-side tuser
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

  // fixed field widths of the stream items
  localparam int NOW_BITS        = 32;
  localparam int INDEX_BITS      = 6;
  localparam int ENTRY_TIME_BITS = 32;
  localparam int CHORD_BITS      = 8;
  localparam int LENGTH_BITS     = 7;
  localparam int DRIVE_BITS      = 8;
  localparam int PULSE_BITS      = 16;

  // score entry as held in the score memory: chord above time
  localparam int ENTRY_BITS = ENTRY_TIME_BITS + CHORD_BITS;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_TDATA_BITS  = 88;
  localparam int IN_TUSER_BITS  = 8;
  localparam int OUT_TDATA_BITS = 16;

  // pulse length after reset
  localparam logic [PULSE_BITS-1:0] PULSE_RESET = 16'd50;

  // one input item, unpacked
  typedef struct packed {
    kind_t                        kind;
    logic [NOW_BITS-1:0]          now_time;
    logic [INDEX_BITS-1:0]        entry_index;
    logic [ENTRY_TIME_BITS-1:0]   entry_time;
    logic [CHORD_BITS-1:0]        entry_chord;
    logic [LENGTH_BITS-1:0]       sequence_length;
  } item_t;

  // one result item
  typedef struct packed {
    logic                  playing;
    logic [DRIVE_BITS-1:0] mallet_drive;
  } res_t;

endpackage

// ===== sv/timed_chord_sequencer_pulser.sv =====
// results are registered in the output buffer, or in its skid stage on a stall
// throughput: one item per cycle while the skid is empty; the play position feeds
//   the score memory read address; the registered entry is ready for the next tick
// reset: synchronous, clears playback, mallet drives and stamps, pulse length 50
// the score memory is not cleared; unwritten entries read as undefined
module timed_chord_sequencer_pulser #(
  parameter int SCORE_DEPTH = 64,
  parameter int NUM_MALLETS = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tcs_pkg::PULSE_BITS-1:0]       cfg_wdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // now_time, entry_index, entry_time, entry_chord, sequence_length
  input  logic [tcs_pkg::IN_TDATA_BITS-1:0]    s_tdata,
  // kind
  input  logic [tcs_pkg::IN_TUSER_BITS-1:0]    s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // mallet_drive, playing
  output logic [tcs_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);

  import tcs_pkg::*;

  item_t item;
  res_t  res;
  res_t  out_res;
  logic  accept;

  // unpack the input transfer
  assign item.kind            = kind_t'(s_tuser[1:0]);
  assign item.now_time        = s_tdata[31:0];
  assign item.entry_index     = s_tdata[37:32];
  assign item.entry_time      = s_tdata[69:38];
  assign item.entry_chord     = s_tdata[77:70];
  assign item.sequence_length = s_tdata[84:78];

  assign accept = s_tvalid && s_tready;

  tcs_core #(
    .SCORE_DEPTH (SCORE_DEPTH),
    .NUM_MALLETS (NUM_MALLETS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (item),
    .res       (res)
  );

  tcs_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_res  (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // pack the result transfer
  assign m_tdata = {7'd0, out_res.playing, out_res.mallet_drive};

endmodule

// ===== sv/tcs_ram.sv =====
module tcs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/tcs_core.sv =====
module tcs_core #(
  parameter int SCORE_DEPTH = 64,
  parameter int NUM_MALLETS = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tcs_pkg::PULSE_BITS-1:0]   cfg_wdata,
  input  logic                             accept,
  input  tcs_pkg::item_t                   item,
  output tcs_pkg::res_t                    res
);

  import tcs_pkg::*;

  localparam int AW = (SCORE_DEPTH > 1) ? $clog2(SCORE_DEPTH) : 1;
  localparam int PW = $clog2(SCORE_DEPTH + 1);

  // playback and mallet state
  logic [NUM_MALLETS-1:0] strike_active, strike_active_next;
  logic [TIME_BITS-1:0]   strike_stamp [NUM_MALLETS];
  logic [TIME_BITS-1:0]   strike_stamp_next [NUM_MALLETS];
  logic                   play_flag, play_flag_next;
  logic [PW-1:0]          play_position, play_position_next;
  logic [PW-1:0]          play_limit, play_limit_next;
  logic [TIME_BITS-1:0]   start_stamp, start_stamp_next;
  logic [PULSE_BITS-1:0]  pulse_duration;

  // score memory access and write-to-read forwarding
  logic                   wr_en;
  logic [AW-1:0]          waddr;
  logic [ENTRY_BITS-1:0]  wdata;
  logic [AW-1:0]          raddr;
  logic [ENTRY_BITS-1:0]  ram_rdata;
  logic                   fwd_hit;
  logic [ENTRY_BITS-1:0]  fwd_data;

  // current entry and timing
  logic [ENTRY_BITS-1:0]  cur_entry;
  logic [TIME_BITS-1:0]   cur_time;
  logic [NUM_MALLETS-1:0] cur_chord;
  logic [TIME_BITS-1:0]   now_t;
  logic [TIME_BITS-1:0]   elapsed;
  logic [NUM_MALLETS-1:0] held_done;
  logic [PW-1:0]          position_inc;
  logic [PW-1:0]          length_sat;

  tcs_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (SCORE_DEPTH)
  ) u_score (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // entry at the play position, with a same-cycle write forwarded
  assign cur_entry = fwd_hit ? fwd_data : ram_rdata;
  assign cur_time  = TIME_BITS'(cur_entry[ENTRY_TIME_BITS-1:0]);
  assign cur_chord = cur_entry[ENTRY_TIME_BITS +: NUM_MALLETS];

  assign now_t        = TIME_BITS'(item.now_time);
  assign elapsed      = now_t - start_stamp;
  assign position_inc = play_position + PW'(1);
  assign length_sat   = (32'(item.sequence_length) > 32'(SCORE_DEPTH)) ?
                        PW'(SCORE_DEPTH) : PW'(item.sequence_length);

  // per-mallet hold timers compared in parallel
  always_comb begin
    for (int i = 0; i < NUM_MALLETS; i++) begin
      held_done[i] = (now_t - strike_stamp[i]) >= TIME_BITS'(pulse_duration);
    end
  end

  // write port follows the item, read port follows the next play position
  assign waddr = AW'(item.entry_index);
  assign wdata = {item.entry_chord, item.entry_time};
  assign raddr = play_position_next[AW-1:0];

  // next state for one accepted item
  always_comb begin
    strike_active_next = strike_active;
    strike_stamp_next  = strike_stamp;
    play_flag_next     = play_flag;
    play_position_next = play_position;
    play_limit_next    = play_limit;
    start_stamp_next   = start_stamp;
    wr_en              = 1'b0;
    if (accept) begin
      case (item.kind)
        KIND_WRITE: begin
          wr_en = 32'(item.entry_index) < 32'(SCORE_DEPTH);
        end
        KIND_START: begin
          play_flag_next     = 1'b1;
          play_position_next = '0;
          play_limit_next    = length_sat;
          start_stamp_next   = now_t;
        end
        KIND_TICK: begin
          // release mallets held long enough
          for (int i = 0; i < NUM_MALLETS; i++) begin
            if (strike_active[i] && held_done[i]) begin
              strike_active_next[i] = 1'b0;
            end
          end
          // fire the current entry once its offset is reached
          if (play_flag) begin
            if (play_position >= play_limit) begin
              play_flag_next = 1'b0;
            end else if (elapsed >= cur_time) begin
              for (int i = 0; i < NUM_MALLETS; i++) begin
                if (cur_chord[i]) begin
                  strike_active_next[i] = 1'b1;
                  strike_stamp_next[i]  = now_t;
                end
              end
              play_position_next = position_inc;
              if (position_inc >= play_limit) begin
                play_flag_next = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strike_active  <= '0;
      strike_stamp   <= '{default: '0};
      play_flag      <= 1'b0;
      play_position  <= '0;
      play_limit     <= '0;
      start_stamp    <= '0;
      pulse_duration <= PULSE_RESET;
      fwd_hit        <= 1'b0;
    end else begin
      strike_active <= strike_active_next;
      strike_stamp  <= strike_stamp_next;
      play_flag     <= play_flag_next;
      play_position <= play_position_next;
      play_limit    <= play_limit_next;
      start_stamp   <= start_stamp_next;
      fwd_hit       <= wr_en && (waddr == raddr);
      if (cfg_we) begin
        pulse_duration <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= wdata;
  end

  // result reflects the state after the item
  assign res.mallet_drive = DRIVE_BITS'(strike_active_next);
  assign res.playing      = play_flag_next;

  // position never runs past the limit
  a_pos_in_limit: assert property (@(posedge clk) disable iff (rst)
    play_position <= play_limit)
    else $error("play position beyond limit");

  // only ticks move the mallets
  a_no_strike_off_tick: assert property (@(posedge clk) disable iff (rst)
    (accept && item.kind != KIND_TICK) |=> $stable(strike_active))
    else $error("mallets changed on a non-tick item");

  // position steps by one at most, or restarts
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (play_position == $past(play_position)) ||
               (play_position == $past(play_position) + PW'(1)) ||
               (play_position == '0))
    else $error("play position jumped");

endmodule

// ===== sv/tcs_out_buf.sv =====
module tcs_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcs_pkg::res_t push_res,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tcs_pkg::res_t out_res
);

  import tcs_pkg::*;

  logic skid_valid;
  res_t skid_res;
  logic pop;

  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  // output register with one skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_res <= push_res;
      end else begin
        out_res <= push_res;
      end
    end
  end

  // skid stage is only ever used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds data with output empty");

  // skid fills only when the output is stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready && push))
    else $error("skid filled without a stall");

endmodule

// ===== dv/timed_chord_sequencer_pulser_tb.sv =====
module timed_chord_sequencer_pulser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcs_pkg::*;

  localparam int SCORE_SLOTS = 64;
  localparam int MALLETS     = 8;

  // kind code the block does not use
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // bit positions inside the slave-side tdata
  localparam int NOW_LSB   = 0;
  localparam int IDX_LSB   = NOW_LSB + NOW_BITS;
  localparam int ETIME_LSB = IDX_LSB + INDEX_BITS;
  localparam int CHORD_LSB = ETIME_LSB + ENTRY_TIME_BITS;
  localparam int LEN_LSB   = CHORD_LSB + CHORD_BITS;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [PULSE_BITS-1:0]     cfg_wdata;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata;
  logic [IN_TUSER_BITS-1:0]  s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;

  timed_chord_sequencer_pulser dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  logic [ENTRY_TIME_BITS-1:0] score_at    [SCORE_SLOTS];
  logic [CHORD_BITS-1:0]      score_notes [SCORE_SLOTS];
  logic [SCORE_SLOTS-1:0]     score_written;
  logic [NOW_BITS-1:0]        strike_at   [MALLETS];
  logic [DRIVE_BITS-1:0]      strike_mask;
  logic                       playing_now;
  logic [LENGTH_BITS-1:0]     play_pos;
  logic [LENGTH_BITS-1:0]     play_end;
  logic [NOW_BITS-1:0]        play_origin;
  logic [PULSE_BITS-1:0]      pulse_len;

  res_t drive_q[$];
  res_t want_r;
  res_t got_r;
  int   fail_count;
  int   sent_count;
  int   rx_hold;
  int   rx_stall_left;
  bit   tx_quiet;
  bit   rx_quiet;
  bit   no_gap;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // number of score slots written from slot 0 up without a hole
  function automatic int score_prefix();
    int n;
    n = 0;
    while (n < SCORE_SLOTS && score_written[n]) n++;
    return n;
  endfunction

  // advance the predicted state by one accepted transfer
  function automatic res_t predict_strikes(input logic [IN_TUSER_BITS-1:0] tuser,
                                           input logic [IN_TDATA_BITS-1:0] tdata);
    logic [1:0]                 k;
    logic [NOW_BITS-1:0]        now;
    logic [INDEX_BITS-1:0]      slot;
    logic [LENGTH_BITS-1:0]     len;
    logic [CHORD_BITS-1:0]      notes;
    logic [NOW_BITS-1:0]        held;
    res_t                       r;
    k    = tuser[1:0];
    now  = tdata[NOW_LSB +: NOW_BITS];
    slot = tdata[IDX_LSB +: INDEX_BITS];
    len  = tdata[LEN_LSB +: LENGTH_BITS];
    case (k)
      KIND_WRITE: begin
        score_at[slot]      = tdata[ETIME_LSB +: ENTRY_TIME_BITS];
        score_notes[slot]   = tdata[CHORD_LSB +: CHORD_BITS];
        score_written[slot] = 1'b1;
      end
      KIND_START: begin
        playing_now = 1'b1;
        play_pos    = '0;
        play_end    = (len > 7'(SCORE_SLOTS)) ? 7'(SCORE_SLOTS) : len;
        play_origin = now;
      end
      KIND_TICK: begin
        // release mallets held long enough
        for (int i = 0; i < MALLETS; i++) begin
          if (strike_mask[i]) begin
            held = now - strike_at[i];
            if (held >= {16'd0, pulse_len}) strike_mask[i] = 1'b0;
          end
        end
        // at most one score entry per tick
        if (playing_now) begin
          if (play_pos >= play_end) begin
            playing_now = 1'b0;
          end else begin
            held  = now - play_origin;
            notes = score_notes[play_pos[INDEX_BITS-1:0]];
            if (held >= score_at[play_pos[INDEX_BITS-1:0]]) begin
              for (int i = 0; i < MALLETS; i++) begin
                if (notes[i]) begin
                  strike_mask[i] = 1'b1;
                  strike_at[i]   = now;
                end
              end
              play_pos = play_pos + 7'd1;
              if (play_pos >= play_end) playing_now = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    r.mallet_drive = strike_mask;
    r.playing      = playing_now;
    return r;
  endfunction

  // predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) drive_q.push_back(predict_strikes(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got_r.mallet_drive = m_tdata[DRIVE_BITS-1:0];
        got_r.playing      = m_tdata[DRIVE_BITS];
        if (drive_q.size() == 0) begin
          $display("%0t: result with no expectation, expected none actual %h",
                   $time, m_tdata);
          fail_count++;
        end else begin
          want_r = drive_q.pop_front();
          if (got_r.mallet_drive !== want_r.mallet_drive) begin
            $display("%0t: mallet_drive mismatch, expected %h actual %h",
                     $time, want_r.mallet_drive, got_r.mallet_drive);
            fail_count++;
          end
          if (got_r.playing !== want_r.playing) begin
            $display("%0t: playing mismatch, expected %b actual %b",
                     $time, want_r.playing, got_r.playing);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked for
  initial begin
    rx_stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready = 1'b0;
        rx_hold--;
      end else if (rx_stall_left > 0) begin
        m_tready = 1'b0;
        rx_stall_left--;
      end else begin
        m_tready      = 1'b1;
        rx_stall_left = rx_quiet ? 0 : pick_gap();
      end
    end
  end

  // offer one item and hold it until the transfer, then maybe idle
  task automatic send_item(input logic [1:0] k, input logic [NOW_BITS-1:0] now,
                           input logic [INDEX_BITS-1:0] slot,
                           input logic [ENTRY_TIME_BITS-1:0] etime,
                           input logic [CHORD_BITS-1:0] notes,
                           input logic [LENGTH_BITS-1:0] len);
    int gap;
    s_tvalid = 1'b1;
    s_tdata  = {3'b000, len, notes, etime, slot, now};
    s_tuser  = {6'b000000, k};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent_count++;
    gap = (no_gap || tx_quiet) ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    s_tvalid = 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_pulse(input logic [PULSE_BITS-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    pulse_len = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // occasional stray item in the middle of a phrase
  task automatic maybe_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3)
      send_item(KIND_UNUSED, $urandom, 6'($urandom), $urandom, 8'($urandom),
                7'($urandom));
    else if (r < 6)
      send_item(KIND_WRITE, $urandom, 6'($urandom), $urandom, 8'($urandom),
                7'($urandom));
    else if (r < 7)
      send_item(KIND_START, $urandom, 6'($urandom), $urandom, 8'($urandom),
                7'($urandom_range(0, score_prefix())));
  endtask

  // write a short score, play it and let the mallets fall back
  task automatic play_phrase();
    int                  n;
    int                  len;
    int                  r;
    int                  ticks;
    logic [NOW_BITS-1:0] t;
    logic [NOW_BITS-1:0] off;
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    n   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SCORE_SLOTS) :
                                         $urandom_range(1, 8);
    off = $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      send_item(KIND_WRITE, $urandom, 6'(i), off,
                ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom), 7'($urandom));
      off = off + $urandom_range(0, 12);
      maybe_noise();
    end
    r = $urandom_range(0, 99);
    if (r < 70)
      len = n;
    else if (r < 82)
      len = $urandom_range(0, score_prefix());
    else if (r < 88)
      len = 0;
    else if (score_prefix() == SCORE_SLOTS)
      len = $urandom_range(SCORE_SLOTS + 1, 127);
    else
      len = n;
    t = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 200) : $urandom;
    send_item(KIND_START, t, 6'($urandom), $urandom, 8'($urandom), 7'(len));
    ticks = 0;
    while (playing_now && ticks < 600) begin
      t = t + (($urandom_range(0, 39) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 6));
      send_item(KIND_TICK, t, 6'($urandom), $urandom, 8'($urandom), 7'($urandom));
      maybe_noise();
      ticks++;
    end
    // a few late ticks so that held mallets get released
    repeat ($urandom_range(1, 4)) begin
      t = t + (($urandom_range(0, 2) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 60));
      send_item(KIND_TICK, t, 6'($urandom), $urandom, 8'($urandom), 7'($urandom));
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // edge values of every field, each kind and the corner cases
  task automatic test_directed();
    send_item(KIND_UNUSED, 32'h0, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_TICK, 32'h0, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_WRITE, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'hFF, 7'd0);
    send_item(KIND_WRITE, 32'h0, 6'd63, 32'hFFFF_FFFF, 8'h00, 7'd127);
    send_item(KIND_WRITE, 32'h0, 6'd1, 32'hFFFF_FFFF, 8'h01, 7'd0);
    send_item(KIND_WRITE, 32'h0, 6'd2, 32'd3, 8'h80, 7'd0);
    // zero length: playing set, then cleared by the next tick with no strike
    send_item(KIND_START, 32'h0, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_TICK, 32'd1, 6'd0, 32'h0, 8'h00, 7'd0);
    // playback across the time wrap
    send_item(KIND_START, 32'hFFFF_FFF8, 6'd0, 32'h0, 8'h00, 7'd2);
    send_item(KIND_TICK, 32'hFFFF_FFF8, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_TICK, 32'hFFFF_FFF8, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_UNUSED, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF, 7'd127);
    // rewrite the pending entry while playing
    send_item(KIND_WRITE, 32'h0, 6'd1, 32'd4, 8'h01, 7'd0);
    send_item(KIND_TICK, 32'd2, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_TICK, 32'd51, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_TICK, 32'd52, 6'd0, 32'h0, 8'h00, 7'd0);
    settle();
    // zero pulse length, one entry per tick even when several are due
    write_pulse(16'd0);
    send_item(KIND_START, 32'd100, 6'd0, 32'h0, 8'h00, 7'd3);
    send_item(KIND_TICK, 32'd200, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_TICK, 32'd200, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_TICK, 32'd200, 6'd0, 32'h0, 8'h00, 7'd0);
    send_item(KIND_TICK, 32'd201, 6'd0, 32'h0, 8'h00, 7'd0);
    settle();
  endtask

  // fill the whole score and play it with an over-long length
  task automatic test_full_score();
    logic [NOW_BITS-1:0] off;
    logic [NOW_BITS-1:0] t;
    int                  ticks;
    off = 0;
    for (int i = 0; i < SCORE_SLOTS; i++) begin
      send_item(KIND_WRITE, $urandom, 6'(i), off, 8'($urandom), 7'($urandom));
      off = off + $urandom_range(0, 3);
    end
    t = $urandom;
    send_item(KIND_START, t, 6'($urandom), $urandom, 8'($urandom),
              7'($urandom_range(SCORE_SLOTS + 1, 127)));
    ticks = 0;
    while (playing_now && ticks < 1000) begin
      t = t + $urandom_range(0, 2);
      send_item(KIND_TICK, t, 6'($urandom), $urandom, 8'($urandom), 7'($urandom));
      ticks++;
    end
    settle();
  endtask

  // random phrases under several pulse lengths
  task automatic test_pulse_settings();
    logic [PULSE_BITS-1:0] pulses [5];
    int                    first;
    pulses = '{16'd50, 16'd1, 16'hFFFF, 16'($urandom_range(2, 2000)), 16'd0};
    foreach (pulses[p]) begin
      settle();
      write_pulse(pulses[p]);
      first = sent_count;
      while (sent_count - first < 330) play_phrase();
    end
    settle();
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    logic [NOW_BITS-1:0] t;
    t       = $urandom;
    no_gap  = 1'b1;
    rx_hold = 300;
    send_item(KIND_START, t, 6'($urandom), $urandom, 8'($urandom), 7'(score_prefix()));
    repeat (60) begin
      t = t + $urandom_range(0, 4);
      send_item(KIND_TICK, t, 6'($urandom), $urandom, 8'($urandom), 7'($urandom));
    end
    no_gap = 1'b0;
    settle();
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    m_tready      = 1'b0;
    rx_hold       = 0;
    tx_quiet      = 1'b0;
    rx_quiet      = 1'b0;
    no_gap        = 1'b0;
    fail_count    = 0;
    sent_count    = 0;
    score_written = '0;
    strike_mask   = '0;
    playing_now   = 1'b0;
    play_pos      = '0;
    play_end      = '0;
    play_origin   = '0;
    pulse_len     = PULSE_RESET;
    foreach (strike_at[i]) strike_at[i] = '0;
    foreach (score_at[i]) begin
      score_at[i]    = '0;
      score_notes[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_full_score();
    test_pulse_settings();
    test_backpressure();

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("timed_chord_sequencer_pulser verification clean");
    else
      $display("timed_chord_sequencer_pulser verification failed");
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("timed_chord_sequencer_pulser verification failed");
    $finish;
  end

endmodule
